>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge once out of reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Trigger in one cycle implies the outcome in the next.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/plr_pkg.sv
`default_nettype none

package plr_pkg;

  localparam int RAM_BYTES  = 8192;
  localparam int ADDR_W     = $clog2(RAM_BYTES);
  localparam int BANK_DEPTH = RAM_BYTES / 2;
  localparam int BANK_AW    = ADDR_W - 1;
  localparam int DATA_W     = 32;

  typedef logic [2:0] cmd_code_t;

  localparam cmd_code_t CMD_READ8   = 3'd0;
  localparam cmd_code_t CMD_READ16  = 3'd1;
  localparam cmd_code_t CMD_READ32  = 3'd2;
  localparam cmd_code_t CMD_WRITE8  = 3'd3;
  localparam cmd_code_t CMD_WRITE16 = 3'd4;
  localparam cmd_code_t CMD_WRITE32 = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_ENTRY,
    ST_LATCH,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic access;
    logic entry_rd;
    logic latch;
    logic emit;
    logic slot_adv;
  } plr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic out_free;
    logic is_read;
    logic is_write;
    logic is_wide;
    logic slot;
  } plr_stat_t;

endpackage

`default_nettype wire

>>> src/plr_ram.sv
`default_nettype none

module plr_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/plr_ctrl.sv
`default_nettype none

module plr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plr_pkg::plr_stat_t  stat,
  output plr_pkg::plr_cmd_t   cmd
);

  import plr_pkg::*;

  `include "assert_macros.svh"

  state_t state_r;
  state_t state_nxt;
  logic   more_slots;

  assign more_slots = stat.is_wide && !stat.slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (stat.is_read) begin
          state_nxt = ST_LATCH;
        end else if (stat.is_write) begin
          state_nxt = ST_ENTRY;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ENTRY: state_nxt = ST_LATCH;
      ST_LATCH: begin
        if (stat.is_read && more_slots) begin
          state_nxt = ST_ACCESS;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          if (stat.is_write && more_slots) begin
            state_nxt = ST_ACCESS;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_ACCESS: cmd.access = 1'b1;
      ST_ENTRY:  cmd.entry_rd = 1'b1;
      ST_LATCH: begin
        cmd.latch    = 1'b1;
        cmd.slot_adv = stat.is_read && more_slots;
      end
      ST_EMIT: begin
        cmd.emit     = stat.out_free;
        cmd.slot_adv = stat.out_free && stat.is_write && more_slots;
      end
      default: cmd = '0;
    endcase
  end

  `ASSERT_HOLDS(a_latch_after_mem, (state_r == ST_LATCH) |-> $past(state_r == ST_ACCESS || state_r == ST_ENTRY), "latch without a preceding RAM read")

endmodule

`default_nettype wire

>>> src/plr_dp.sv
`default_nettype none

module plr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [2:0]                   in_command,
  input  logic [plr_pkg::ADDR_W-1:0]   in_address,
  input  logic [plr_pkg::DATA_W-1:0]   in_write_data,
  input  plr_pkg::plr_cmd_t            cmd,
  output plr_pkg::plr_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plr_pkg::DATA_W-1:0]   out_read_data,
  output logic                         out_color_valid,
  output logic [plr_pkg::BANK_AW-1:0]  out_color_index,
  output logic [4:0]                   out_red,
  output logic [4:0]                   out_green,
  output logic [4:0]                   out_blue,
  output logic [plr_pkg::ADDR_W-1:0]   out_next_address,
  output logic                         out_last
);

  import plr_pkg::*;

  `include "assert_macros.svh"

  // Request registers
  cmd_code_t           cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   wdata_r;
  logic                slot_r;
  logic [DATA_W-1:0]   acc_r;
  logic [DATA_W-1:0]   acc_nxt;
  logic [15:0]         ent_r;
  logic [BANK_AW-1:0]  clr_cnt_r;

  // Result register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_read_data_r;
  logic                out_color_valid_r;
  logic [BANK_AW-1:0]  out_color_index_r;
  logic [4:0]          out_red_r;
  logic [4:0]          out_green_r;
  logic [4:0]          out_blue_r;
  logic [ADDR_W-1:0]   out_next_address_r;
  logic                out_last_r;

  logic                is_read;
  logic                is_write;
  logic                is_wide;
  logic                is_byte;
  logic [2:0]          size;
  logic [ADDR_W-1:0]   slot_addr;
  logic [ADDR_W-1:0]   slot_addr_p1;
  logic [ADDR_W-1:0]   even_addr;
  logic [BANK_AW-1:0]  even_idx;
  logic [BANK_AW-1:0]  odd_idx;
  logic [ADDR_W-1:0]   next_addr;
  logic [7:0]          byte_hi;
  logic [7:0]          byte_lo;
  logic [7:0]          rd_x;
  logic [7:0]          rd_x1;

  logic                e_en, e_we, o_en, o_we;
  logic [BANK_AW-1:0]  e_addr, o_addr;
  logic [7:0]          e_wdata, o_wdata, e_q, o_q;

  always_comb begin
    is_read  = (cmd_r == CMD_READ8) || (cmd_r == CMD_READ16) || (cmd_r == CMD_READ32);
    is_write = (cmd_r == CMD_WRITE8) || (cmd_r == CMD_WRITE16) || (cmd_r == CMD_WRITE32);
    is_wide  = (cmd_r == CMD_READ32) || (cmd_r == CMD_WRITE32);
    is_byte  = (cmd_r == CMD_READ8) || (cmd_r == CMD_WRITE8);
    case (cmd_r)
      CMD_READ8, CMD_WRITE8:   size = 3'd1;
      CMD_READ16, CMD_WRITE16: size = 3'd2;
      CMD_READ32, CMD_WRITE32: size = 3'd4;
      default:                 size = 3'd0;
    endcase
  end

  // Byte lanes: the pair starting at slot_addr touches one even and one odd byte.
  assign slot_addr    = addr_r + ADDR_W'({slot_r, 1'b0});
  assign slot_addr_p1 = slot_addr + ADDR_W'(1);
  assign even_addr    = slot_addr[0] ? slot_addr_p1 : slot_addr;
  assign even_idx     = even_addr[ADDR_W-1:1];
  assign odd_idx      = slot_addr[ADDR_W-1:1];
  assign next_addr    = addr_r + ADDR_W'(size);

  always_comb begin
    if (is_byte) begin
      byte_hi = wdata_r[7:0];
      byte_lo = wdata_r[7:0];
    end else if (is_wide && !slot_r) begin
      byte_hi = wdata_r[31:24];
      byte_lo = wdata_r[23:16];
    end else begin
      byte_hi = wdata_r[15:8];
      byte_lo = wdata_r[7:0];
    end
  end

  always_comb begin
    e_en    = 1'b0;
    e_we    = 1'b0;
    o_en    = 1'b0;
    o_we    = 1'b0;
    e_addr  = even_idx;
    o_addr  = odd_idx;
    e_wdata = slot_addr[0] ? byte_lo : byte_hi;
    o_wdata = slot_addr[0] ? byte_hi : byte_lo;
    if (cmd.clear) begin
      e_en    = 1'b1;
      e_we    = 1'b1;
      o_en    = 1'b1;
      o_we    = 1'b1;
      e_addr  = clr_cnt_r;
      o_addr  = clr_cnt_r;
      e_wdata = '0;
      o_wdata = '0;
    end else if (cmd.access && is_read) begin
      e_en = 1'b1;
      o_en = 1'b1;
    end else if (cmd.access && is_write) begin
      e_en = !slot_addr[0] || !is_byte;
      o_en = slot_addr[0] || !is_byte;
      e_we = 1'b1;
      o_we = 1'b1;
    end else if (cmd.entry_rd) begin
      // The colour entry sits at the same word index in both banks.
      e_en   = 1'b1;
      o_en   = 1'b1;
      e_addr = odd_idx;
    end
  end

  plr_ram #(.DEPTH(BANK_DEPTH), .WIDTH(8)) u_even (
    .clk   (clk),
    .en    (e_en),
    .we    (e_we),
    .addr  (e_addr),
    .wdata (e_wdata),
    .rdata (e_q)
  );

  plr_ram #(.DEPTH(BANK_DEPTH), .WIDTH(8)) u_odd (
    .clk   (clk),
    .en    (o_en),
    .we    (o_we),
    .addr  (o_addr),
    .wdata (o_wdata),
    .rdata (o_q)
  );

  assign rd_x  = slot_addr[0] ? o_q : e_q;
  assign rd_x1 = slot_addr[0] ? e_q : o_q;
  assign acc_nxt = is_byte ? {24'b0, rd_x} : {acc_r[15:0], rd_x, rd_x1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + BANK_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_command;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      slot_r  <= 1'b0;
      acc_r   <= '0;
    end else begin
      if (cmd.slot_adv) slot_r <= 1'b1;
      if (cmd.latch && is_read) acc_r <= acc_nxt;
    end
    if (cmd.latch && !is_read) ent_r <= {e_q, o_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_read_data_r    <= is_read ? acc_r : '0;
      out_color_valid_r  <= is_write;
      out_color_index_r  <= is_write ? odd_idx : '0;
      out_red_r          <= is_write ? {ent_r[3:0], ent_r[12]} : '0;
      out_green_r        <= is_write ? {ent_r[7:4], ent_r[13]} : '0;
      out_blue_r         <= is_write ? {ent_r[11:8], ent_r[14]} : '0;
      out_next_address_r <= next_addr;
      out_last_r         <= !(is_write && is_wide && !slot_r);
    end
  end

  assign stat.clr_done = (clr_cnt_r == {BANK_AW{1'b1}});
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.is_read  = is_read;
  assign stat.is_write = is_write;
  assign stat.is_wide  = is_wide;
  assign stat.slot     = slot_r;

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_color_valid  = out_color_valid_r;
  assign out_color_index  = out_color_index_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_next_address = out_next_address_r;
  assign out_last         = out_last_r;

  `ASSERT_HOLDS(a_color_no_rdata, out_valid_r && out_color_valid_r |-> out_read_data_r == '0, "colour result carries read data")
  `ASSERT_HOLDS(a_first_is_color, out_valid_r && !out_last_r |-> out_color_valid_r, "non-final result without colour")

endmodule

`default_nettype wire

>>> src/palette_ram_with_rgb_expand_core.sv
// Byte-addressed palette RAM (8 KiB) with RGB444-plus-extra-bit to RGB555
// expansion. Each input request is one big-endian bus access: read or
// write of 8, 16 or 32 bits at any byte address, wrapping at the top of
// the RAM. A read gives one result with the assembled data; a write of 8
// or 16 bits gives one result carrying the refreshed colour entry, a
// 32-bit write gives two (the first with out_last low). The RAM is split
// into an even-byte and an odd-byte bank of 4096 x 8, so any two adjacent
// bytes move in a single bank access. Requests are worked one at a time;
// the single port of each bank sets the steps: a read reads and then
// registers each byte pair; a write writes, then reads back the entry,
// then registers it, before each result. A new request is taken as soon
// as the previous one has been handed to the result register, even while
// that result still waits. After reset the block clears both banks, one
// word a cycle, and holds in_ready low until the clear is done.
`default_nettype none

module palette_ram_with_rgb_expand_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_command,
  input  logic [plr_pkg::ADDR_W-1:0]   in_address,
  input  logic [plr_pkg::DATA_W-1:0]   in_write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plr_pkg::DATA_W-1:0]   out_read_data,
  output logic                         out_color_valid,
  output logic [plr_pkg::BANK_AW-1:0]  out_color_index,
  output logic [4:0]                   out_red,
  output logic [4:0]                   out_green,
  output logic [4:0]                   out_blue,
  output logic [plr_pkg::ADDR_W-1:0]   out_next_address,
  output logic                         out_last
);

  import plr_pkg::*;

  `include "assert_macros.svh"

  plr_cmd_t  cmd;
  plr_stat_t stat;

  // Sequence the clear after reset, then each request: access, entry read-back, latch, emit.
  plr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the request, drive the two banks and build each result.
  plr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_color_valid  (out_color_valid),
    .out_color_index  (out_color_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_next_address (out_next_address),
    .out_last         (out_last)
  );

  // A request in flight blocks the next one.
  `ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken while busy")

endmodule

`default_nettype wire
